@@ rtl/desks_pkg.sv @@
// Shared constants, tables and helper functions for the DES round key schedule.
package desks_pkg;

  localparam int KEY_W       = 64;
  localparam int HALF_W      = 28;
  localparam int CD_W        = 2 * HALF_W;
  localparam int SUBKEY_W    = 48;
  localparam int ROUNDS      = 16;
  localparam int ROUND_W     = $clog2(ROUNDS);
  // The queue depth must be a power of two so the pointers wrap on their own.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUNDS - 1);

  typedef logic [7:0] sel_t;

  // Key permutation that builds the halves: DES bit numbers of the key, C half first.
  localparam sel_t PC1_TBL [CD_W] = '{
    8'd57, 8'd49, 8'd41, 8'd33, 8'd25, 8'd17, 8'd9,  8'd1,  8'd58, 8'd50, 8'd42, 8'd34,
    8'd26, 8'd18, 8'd10, 8'd2,  8'd59, 8'd51, 8'd43, 8'd35, 8'd27, 8'd19, 8'd11, 8'd3,
    8'd60, 8'd52, 8'd44, 8'd36, 8'd63, 8'd55, 8'd47, 8'd39, 8'd31, 8'd23, 8'd15, 8'd7,
    8'd62, 8'd54, 8'd46, 8'd38, 8'd30, 8'd22, 8'd14, 8'd6,  8'd61, 8'd53, 8'd45, 8'd37,
    8'd29, 8'd21, 8'd13, 8'd5,  8'd28, 8'd20, 8'd12, 8'd4
  };

  // Subkey selection: bit numbers of C:D, counted from 1 at the MSB.
  localparam sel_t PC2_TBL [SUBKEY_W] = '{
    8'd14, 8'd17, 8'd11, 8'd24, 8'd1,  8'd5,  8'd3,  8'd28, 8'd15, 8'd6,  8'd21, 8'd10,
    8'd23, 8'd19, 8'd12, 8'd4,  8'd26, 8'd8,  8'd16, 8'd7,  8'd27, 8'd20, 8'd13, 8'd2,
    8'd41, 8'd52, 8'd31, 8'd37, 8'd47, 8'd55, 8'd30, 8'd40, 8'd51, 8'd45, 8'd33, 8'd48,
    8'd44, 8'd49, 8'd39, 8'd56, 8'd34, 8'd53, 8'd46, 8'd42, 8'd50, 8'd36, 8'd29, 8'd32
  };

  // Bit r is set where round r rotates by two places, clear where it rotates by one.
  localparam logic [ROUNDS-1:0] ROT_TWO = 16'b0111_1110_1111_1100;

  typedef struct packed {
    logic [HALF_W-1:0] c;
    logic [HALF_W-1:0] d;
  } halves_t;

  // Split a key into the C and D halves.
  function automatic halves_t pc1(input logic [KEY_W-1:0] key);
    logic [CD_W-1:0] cd;
    for (int i = 0; i < CD_W; i++) begin
      cd[CD_W-1-i] = key[KEY_W - int'(PC1_TBL[i])];
    end
    return halves_t'(cd);
  endfunction

  // Rotate one half left by one or two places.
  function automatic logic [HALF_W-1:0] rotl(input logic [HALF_W-1:0] v, input logic two);
    logic [HALF_W-1:0] res;
    if (two) begin
      res = {v[HALF_W-3:0], v[HALF_W-1:HALF_W-2]};
    end else begin
      res = {v[HALF_W-2:0], v[HALF_W-1]};
    end
    return res;
  endfunction

  // Select the 48 subkey bits from C:D.
  function automatic logic [SUBKEY_W-1:0] pc2(input halves_t h);
    logic [CD_W-1:0]     cd;
    logic [SUBKEY_W-1:0] sk;
    cd = CD_W'(h);
    for (int i = 0; i < SUBKEY_W; i++) begin
      sk[SUBKEY_W-1-i] = cd[CD_W - int'(PC2_TBL[i])];
    end
    return sk;
  endfunction

endpackage

@@ rtl/desks_key_if.sv @@
// Channel interface that carries one DES key per word.
interface desks_key_if;
  import desks_pkg::*;

  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key;

  modport source (output valid, output key, input ready);
  modport sink (input valid, input key, output ready);
endinterface

@@ rtl/desks_rkey_if.sv @@
// Channel interface that carries one round key with its index and last flag per word.
interface desks_rkey_if;
  import desks_pkg::*;

  logic                valid;
  logic                ready;
  logic [SUBKEY_W-1:0] round_key;
  logic [ROUND_W-1:0]  round_index;
  logic                last;

  modport source (output valid, output round_key, output round_index, output last,
                  input ready);
  modport sink (input valid, input round_key, input round_index, input last,
                output ready);
endinterface

@@ rtl/desks_front.sv @@
// Front end: takes key words and splits them into C and D halves for the queue.
module desks_front (
  desks_key_if.sink          in_ch,
  output logic               push_valid,
  output desks_pkg::halves_t push_data,
  input  logic               push_ready
);
  import desks_pkg::*;

  // A key is taken whenever the queue has a free slot.
  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;

  // The key permutation into C and D is pure wiring.
  assign push_data = pc1(in_ch.key);
endmodule

@@ rtl/desks_queue.sv @@
// Short queue of C/D half pairs between the front end and the round sequencer.
module desks_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  input  desks_pkg::halves_t push_data,
  output logic               push_ready,
  output logic               pop_valid,
  output desks_pkg::halves_t pop_data,
  input  logic               pop_ready
);
  import desks_pkg::*;

  halves_t             mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]   count_r, count_nxt;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (count_r != (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end
endmodule

@@ rtl/desks_back.sv @@
// Round sequencer: rotates C and D once per round and registers each subkey for output.
module desks_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  input  desks_pkg::halves_t pop_data,
  output logic               pop_ready,
  desks_rkey_if.source       out_ch
);
  import desks_pkg::*;

  logic                busy_r, busy_nxt;
  logic [ROUND_W-1:0]  round_r, round_nxt;
  halves_t             cd_r, cd_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SUBKEY_W-1:0] round_key_r, round_key_nxt;
  logic [ROUND_W-1:0]  round_index_r, round_index_nxt;
  logic                last_r, last_nxt;
  halves_t             cd_rot;
  logic                slot_free;
  logic                advance;
  logic                load;

  // Halves after this round's rotation.
  assign cd_rot.c = rotl(cd_r.c, ROT_TWO[round_r]);
  assign cd_rot.d = rotl(cd_r.d, ROT_TWO[round_r]);

  // A round runs when the output register is empty or its word leaves this cycle.
  assign slot_free = !out_valid_r || out_ch.ready;
  assign advance   = busy_r && slot_free;
  assign pop_ready = !busy_r || (advance && (round_r == LAST_ROUND));
  assign load      = pop_valid && pop_ready;

  always_comb begin
    busy_nxt        = busy_r;
    round_nxt       = round_r;
    cd_nxt          = cd_r;
    out_valid_nxt   = out_valid_r;
    round_key_nxt   = round_key_r;
    round_index_nxt = round_index_r;
    last_nxt        = last_r;

    // Drop the output word once it has been taken.
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    // Produce one round key.
    if (advance) begin
      out_valid_nxt   = 1'b1;
      round_key_nxt   = pc2(cd_rot);
      round_index_nxt = round_r;
      last_nxt        = (round_r == LAST_ROUND);
      cd_nxt          = cd_rot;
      round_nxt       = round_r + 1'b1;
      if (round_r == LAST_ROUND) begin
        busy_nxt = 1'b0;
      end
    end

    // Start the next key right behind the last round of the previous one.
    if (load) begin
      busy_nxt  = 1'b1;
      round_nxt = '0;
      cd_nxt    = pop_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      round_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      round_r     <= round_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cd_r          <= cd_nxt;
    round_key_r   <= round_key_nxt;
    round_index_r <= round_index_nxt;
    last_r        <= last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.round_key   = round_key_r;
  assign out_ch.round_index = round_index_r;
  assign out_ch.last        = last_r;
endmodule

@@ rtl/des_round_key_schedule.sv @@
// DES key schedule: one 64-bit key in, sixteen 48-bit round keys out.
//
// The in_ch channel takes one key word per valid/ready handshake, with DES bit 1
// in the MSB; parity bits are ignored. The out_ch channel gives one word per
// round: the 48-bit subkey selected from C:D, its round index (0 to 15) and a
// last flag on the sixteenth. Keys come out strictly in arrival order.
// The first round key of a key passes through the queue, the C/D register and
// the output register if the block was idle; the rest follow one per cycle
// while out_ch is ready. The round sequencer registers one round key per cycle
// into the single output register, so it sets the sustained key rate.
// A two-entry queue between the key front end and the round sequencer lets
// keys be taken while earlier ones are still being expanded; in_ch.ready
// drops only when that queue is full.
// When out_ch stalls, the output word holds and the sequencer waits on it.
// Synchronous active-low reset empties the queue and the output register.
module des_round_key_schedule (
  input logic          clk,
  input logic          rst_n,
  desks_key_if.sink    in_ch,
  desks_rkey_if.source out_ch
);
  import desks_pkg::*;

  logic    push_valid;
  logic    push_ready;
  halves_t push_data;
  logic    pop_valid;
  logic    pop_ready;
  halves_t pop_data;

  // Key intake and the split into C and D.
  desks_front u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  // Decoupling queue.
  desks_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready)
  );

  // Round rotations, subkey selection and output register.
  desks_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop_ready (pop_ready),
    .out_ch    (out_ch)
  );
endmodule
